[sv/cpa_pkg.sv]
package cpa_pkg;

  // Defaults for the top-level parameters.
  localparam int NUM_PAGES_DEF = 256;
  localparam int PID_BITS_DEF  = 16;

  // Fixed widths of the request, result and register fields.
  localparam int MODE_W  = 2;
  localparam int PIDF_W  = 16;
  localparam int COUNT_W = 9;
  localparam int INDEX_W = 8;
  localparam int STAT_W  = 2;
  localparam int PNUM_W  = 8;
  localparam int ADDR_W  = 24;
  localparam int PIU_W   = 9;
  localparam int PSIZE_W = 17;
  localparam int REG_W   = 17;
  localparam int REGIDX_W = 1;

  localparam int PIU_RESET   = 256;
  localparam int PSIZE_RESET = 256;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_LOCATE = 2'd2
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [REGIDX_W-1:0] {
    REG_PAGES_IN_USE = 1'b0,
    REG_PAGE_SIZE    = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_DONE
  } state_t;

  // Completion of one request, handed from the sequencer to the output stage.
  typedef struct packed {
    logic    done;
    status_t status;
  } res_t;

endpackage

[sv/cpa_ram.sv]
module cpa_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/cpa_seq.sv]
module cpa_seq import cpa_pkg::*; #(
  parameter int NUM_PAGES = NUM_PAGES_DEF,
  parameter int PID_BITS  = PID_BITS_DEF,
  localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1,
  localparam int CW = PW + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                ready,
  input  logic [MODE_W-1:0]   mode,
  input  logic [PID_BITS-1:0] id,
  input  logic [COUNT_W-1:0]  count,
  input  logic [INDEX_W-1:0]  want,
  input  logic [CW-1:0]       limit,
  output logic                ram_we,
  output logic [PW-1:0]       ram_waddr,
  output logic [PID_BITS:0]   ram_wdata,
  output logic [PW-1:0]       ram_raddr,
  input  logic [PID_BITS:0]   ram_rdata,
  input  logic                out_free,
  output res_t                res,
  output logic [PW-1:0]       res_page
);

  localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;

  state_t               state, state_next;
  mode_t                mode_r;
  logic [PID_BITS-1:0]  id_r;
  logic [COUNT_W-1:0]   count_r;
  logic [INDEX_W-1:0]   want_r;
  logic [CW-1:0]        limit_r;
  logic [CW-1:0]        ip;
  logic                 rv;
  logic [PW-1:0]        ra;
  logic [COUNT_W-1:0]   run;
  logic [CW-1:0]        start_pg;
  logic                 found;
  logic [INDEX_W-1:0]   seen;
  logic [PW-1:0]        page_r;
  status_t              status_r;
  logic [COUNT_W-1:0]   fill_left;
  logic [PW-1:0]        wp;
  logic [PW-1:0]        clr;

  logic hit, free_e, alloc_hit, loc_hit, scan_end, issue, bad_alloc;

  // Shared compare unit: one table entry is judged per cycle.
  always_comb begin
    hit       = rv && ram_rdata[PID_BITS] && (ram_rdata[PID_BITS-1:0] == id_r);
    free_e    = rv && !ram_rdata[PID_BITS];
    alloc_hit = free_e && ((run + COUNT_W'(1)) == count_r);
    loc_hit   = hit && (seen == want_r);
    scan_end  = !rv && (ip >= limit_r);
    issue     = ip < limit_r;
    bad_alloc = (count == '0) || (LW'(count) > LW'(limit));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ready      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = clr;
    ram_wdata  = '0;
    ram_raddr  = ip[PW-1:0];
    res.done   = 1'b0;
    res.status = status_r;
    res_page   = page_r;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr == PW'(NUM_PAGES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ready = 1'b1;
        if (start) begin
          priority if (mode_t'(mode) == MODE_ALLOC && bad_alloc) begin
            state_next = S_DONE;
          end else if (mode_t'(mode) == MODE_ALLOC || mode_t'(mode) == MODE_FREE ||
                       mode_t'(mode) == MODE_LOCATE) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (mode_r == MODE_FREE && hit) begin
          ram_we    = 1'b1;
          ram_waddr = ra;
        end
        priority if (mode_r == MODE_ALLOC && alloc_hit) begin
          state_next = S_FILL;
        end else if (mode_r == MODE_LOCATE && loc_hit) begin
          state_next = S_DONE;
        end else if (scan_end) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = wp;
        ram_wdata = {1'b1, id_r};
        if (fill_left == '0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          res.done   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
      rv  <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: clr <= clr + PW'(1);
        S_IDLE: begin
          if (start) begin
            mode_r   <= mode_t'(mode);
            id_r     <= id;
            count_r  <= count;
            want_r   <= want;
            limit_r  <= limit;
            ip       <= '0;
            rv       <= 1'b0;
            run      <= '0;
            start_pg <= '0;
            found    <= 1'b0;
            seen     <= '0;
            page_r   <= '0;
            if (mode_t'(mode) == MODE_ALLOC) begin
              status_r <= STAT_NO_SPACE;
            end else begin
              status_r <= STAT_NOT_FOUND;
            end
          end
        end
        S_SCAN: begin
          rv <= issue;
          ra <= ip[PW-1:0];
          if (issue) begin
            ip <= ip + CW'(1);
          end
          unique case (mode_r)
            MODE_ALLOC: begin
              if (rv) begin
                if (ram_rdata[PID_BITS]) begin
                  run      <= '0;
                  start_pg <= CW'(ra) + CW'(1);
                end else begin
                  run <= run + COUNT_W'(1);
                end
              end
              if (alloc_hit) begin
                wp        <= start_pg[PW-1:0];
                fill_left <= count_r - COUNT_W'(1);
              end
            end
            MODE_FREE: begin
              if (hit) begin
                found    <= 1'b1;
                status_r <= STAT_OK;
                if (!found) begin
                  page_r <= ra;
                end
              end
            end
            MODE_LOCATE: begin
              if (hit) begin
                if (seen == want_r) begin
                  status_r <= STAT_OK;
                  page_r   <= ra;
                end else begin
                  seen <= seen + INDEX_W'(1);
                end
              end
            end
            default: ;
          endcase
        end
        S_FILL: begin
          wp        <= wp + PW'(1);
          fill_left <= fill_left - COUNT_W'(1);
          if (fill_left == '0) begin
            status_r <= STAT_OK;
            page_r   <= start_pg[PW-1:0];
          end
        end
        S_DONE: rv <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

[sv/contiguous_page_allocator.sv]
// First-fit contiguous page allocator. An owner table with one entry per swap
// page records whether the page is free and, if not, which process id owns it.
// A request with mode allocate claims the lowest run of page_count free pages
// for pid and returns its start page; mode free releases every managed page of
// pid and returns the lowest page released; mode locate returns the page_index-th
// page (from zero, in ascending order) owned by pid. Each result also carries the
// byte address, page_number times page_size modulo 2^24, and both are zero when
// the status is not ok. The table lives in a single-port-write RAM with a
// registered read, and a sequencer walks it one entry per cycle through one
// shared compare unit, so a request holds s_axis_tready low while it runs.
// A scan reads all n managed pages (n is pages_in_use saturated at NUM_PAGES)
// for every free, every locate that misses and every allocate that finds no
// room; pages beyond n take part in no scan. A locate that hits stops at that
// page, and an allocate stops at the page that ends its run and then marks the
// run as owned. A bad count or an unused mode is answered without a scan. The
// result enters the output register as the sequencer returns to idle, and the
// next request can be taken in the cycle after. After reset the table is
// cleared entry by entry before the first request is taken; configuration
// writes are accepted throughout. A finished result waits in the output
// register, so the next request may be accepted as soon as the result has been
// moved there; while that register is still full and the result stream stalls,
// the sequencer waits with its own result.
module contiguous_page_allocator import cpa_pkg::*; #(
  parameter int NUM_PAGES = NUM_PAGES_DEF,
  parameter int PID_BITS  = PID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // Request: mode [1:0], pid [17:2], page_count [26:18], page_index [34:27].
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,
  // Result: status [1:0], page_number [9:2], byte_address [33:10].
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata,
  // Configuration write port.
  input  logic                cfg_wr_en,
  input  logic [REGIDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]    cfg_data
);

  localparam int PW     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CW     = PW + 1;
  localparam int LW     = (CW > PIU_W) ? CW : PIU_W;
  localparam int PROD_W = PW + PSIZE_W;

  // Configuration registers.
  logic [PIU_W-1:0]   pages_in_use;
  logic [PSIZE_W-1:0] page_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= PIU_W'(PIU_RESET);
      page_size    <= PSIZE_W'(PSIZE_RESET);
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PAGES_IN_USE: pages_in_use <= cfg_data[PIU_W-1:0];
        REG_PAGE_SIZE:    page_size    <= cfg_data[PSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // The number of pages taking part in a scan saturates at the table size.
  logic [CW-1:0] limit;
  always_comb begin
    if (LW'(pages_in_use) >= LW'(NUM_PAGES)) begin
      limit = CW'(NUM_PAGES);
    end else begin
      limit = CW'(pages_in_use);
    end
  end

  // Request fields; the process id is held to PID_BITS bits.
  logic [MODE_W-1:0]   req_mode;
  logic [PIDF_W-1:0]   req_pid;
  logic [COUNT_W-1:0]  req_count;
  logic [INDEX_W-1:0]  req_index;
  logic [PID_BITS-1:0] req_id;

  assign req_mode  = s_axis_tdata[1:0];
  assign req_pid   = s_axis_tdata[17:2];
  assign req_count = s_axis_tdata[26:18];
  assign req_index = s_axis_tdata[34:27];
  assign req_id    = PID_BITS'(req_pid);

  logic                ram_we;
  logic [PW-1:0]       ram_waddr;
  logic [PID_BITS:0]   ram_wdata;
  logic [PW-1:0]       ram_raddr;
  logic [PID_BITS:0]   ram_rdata;
  logic                out_free;
  res_t                res;
  logic [PW-1:0]       res_page;

  cpa_ram #(
    .WIDTH (PID_BITS + 1),
    .DEPTH (NUM_PAGES)
  ) u_owner_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  cpa_seq #(
    .NUM_PAGES (NUM_PAGES),
    .PID_BITS  (PID_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (s_axis_tvalid && s_axis_tready),
    .ready     (s_axis_tready),
    .mode      (req_mode),
    .id        (req_id),
    .count     (req_count),
    .want      (req_index),
    .limit     (limit),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_free  (out_free),
    .res       (res),
    .res_page  (res_page)
  );

  // Output register. The byte address is formed by the multiplier directly
  // into it; the sequencer holds the page at zero for any failed request.
  logic                out_valid;
  status_t             out_status;
  logic [PNUM_W-1:0]   out_page;
  logic [ADDR_W-1:0]   out_addr;
  logic [PROD_W-1:0]   product;

  assign out_free = !out_valid || m_axis_tready;
  assign product  = PROD_W'(res_page) * PROD_W'(page_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.done) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      out_status <= res.status;
      out_page   <= PNUM_W'(res_page);
      out_addr   <= ADDR_W'(product);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_addr, out_page, out_status};

  // A request that has just been accepted keeps the input closed while it runs.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input reopened straight after a request was accepted");

  // The sequencer only hands over a result when the output register can take it.
  assert property (@(posedge clk) disable iff (rst)
    res.done |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote a pending output");

  // A failed request reports page and address as zero.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_status != STAT_OK |-> out_page == '0 && out_addr == '0)
    else $error("failed request carries a non-zero page or address");

  // Table writes never happen while the block is waiting for a request.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !ram_we)
    else $error("owner table written while idle");

endmodule

[dv/tb_contiguous_page_allocator.sv]
`timescale 1ns / 1ps

module tb_contiguous_page_allocator;
  import cpa_pkg::*;

  localparam int NUM_PAGES = NUM_PAGES_DEF;
  localparam logic [PIDF_W-1:0] PID_MASK = PIDF_W'((1 << PID_BITS_DEF) - 1);

  // The request encoding the block leaves unused; it must answer not_found.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Quiet cycles after the last result before the settings are touched or the
  // run ends. Every request produces exactly one result, so the block has
  // nothing left to do once the last one has been taken.
  localparam int SETTLE_CYCLES = 16;

  // A request costs at most a full scan plus a full fill, plus the longest
  // sender gap and receiver stall. Roughly 1780 requests at that worst case,
  // plus the clearing pass after reset, set the need; the limit is taken well
  // over three times that.
  localparam int CYCLE_LIMIT = 5_000_000;

  localparam int RANDOM_PHASES = 7;
  localparam int RANDOM_PER_PHASE = 250;

  // One predicted result of a request.
  typedef struct packed {
    status_t               status;
    logic [PNUM_W-1:0]     page;
    logic [ADDR_W-1:0]     addr;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // Request: mode [1:0], pid [17:2], page_count [26:18], page_index [34:27].
  logic [39:0]         s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // Result: status [1:0], page_number [9:2], byte_address [33:10].
  logic [39:0]         m_axis_tdata;
  logic                cfg_wr_en = 1'b0;
  logic [REGIDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]    cfg_data  = '0;

  // Our own copy of the owner table and of the two registers, kept in step
  // with the block by applying every accepted request in acceptance order.
  bit                owner_valid [NUM_PAGES];
  logic [PIDF_W-1:0] owner_id    [NUM_PAGES];
  int unsigned       pages_reg = PIU_RESET;
  int unsigned       bytes_reg = PSIZE_RESET;

  // Results that have been predicted but not yet seen on the result stream.
  outcome_t awaited_outcomes [$];

  int error_count = 0;
  int burst_left  = 0;
  int rx_left     = 0;
  int rx_roll;
  logic rx_ready  = 1'b0;
  outcome_t want;

  always #6 clk = ~clk;

  contiguous_page_allocator uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Works out the result of one request and updates the owner table in the
  // same way the block should. Only pages below the managed count are looked
  // at; pages above it keep their owner but stay hidden from every scan.
  function automatic outcome_t compute_outcome(input logic [MODE_W-1:0]  mode,
                                               input logic [PIDF_W-1:0]  pid,
                                               input logic [COUNT_W-1:0] count,
                                               input logic [INDEX_W-1:0] index);
    int limit, run, start, seen, page, p;
    bit hit;
    logic [PIDF_W-1:0] id;
    logic [31:0] product;
    outcome_t o;
    id = pid & PID_MASK;
    limit = (pages_reg < NUM_PAGES) ? pages_reg : NUM_PAGES;
    hit = 1'b0;
    run = 0;
    start = 0;
    seen = 0;
    page = 0;
    o.status = STAT_NOT_FOUND;
    case (mode)
      MODE_ALLOC: begin
        // First fit: the run restarts after every owned page. A count of zero
        // or one larger than the managed pages never fits.
        o.status = STAT_NO_SPACE;
        if (count != 0 && count <= limit) begin
          for (p = 0; p < limit && !hit; p++) begin
            if (owner_valid[p]) begin
              run = 0;
              start = p + 1;
            end else begin
              run++;
              if (run == count) hit = 1'b1;
            end
          end
        end
        if (hit) begin
          for (p = start; p < start + count; p++) begin
            owner_valid[p] = 1'b1;
            owner_id[p] = id;
          end
          o.status = STAT_OK;
          page = start;
        end
      end
      MODE_FREE: begin
        for (p = 0; p < limit; p++) begin
          if (owner_valid[p] && owner_id[p] == id) begin
            if (!hit) page = p;
            hit = 1'b1;
            owner_valid[p] = 1'b0;
            owner_id[p] = '0;
          end
        end
        if (hit) o.status = STAT_OK;
      end
      MODE_LOCATE: begin
        for (p = 0; p < limit && !hit; p++) begin
          if (owner_valid[p] && owner_id[p] == id) begin
            if (seen == index) begin
              hit = 1'b1;
              page = p;
            end else begin
              seen++;
            end
          end
        end
        if (hit) o.status = STAT_OK;
      end
      default: ;
    endcase
    if (o.status == STAT_OK) begin
      product = page * bytes_reg;
      o.page = page[PNUM_W-1:0];
      o.addr = product[ADDR_W-1:0];
    end else begin
      o.page = '0;
      o.addr = '0;
    end
    return o;
  endfunction

  // Sends one request and records its predicted result once the block has
  // taken it. Requests go out in bursts; between bursts tvalid drops for a
  // random gap, now and then long enough to cover a whole table scan.
  task automatic send_request(input logic [MODE_W-1:0]  mode,
                              input logic [PIDF_W-1:0]  pid,
                              input logic [COUNT_W-1:0] count,
                              input logic [INDEX_W-1:0] index);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 300) : $urandom_range(1, 30);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, index, count, pid, mode};
    do @(posedge clk); while (!s_axis_tready);
    awaited_outcomes.push_back(compute_outcome(mode, pid, count, index));
    burst_left--;
    @(negedge clk);
    if (burst_left == 0) s_axis_tvalid <= 1'b0;
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic wait_idle();
    if (burst_left != 0) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
    end
    while (awaited_outcomes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes both registers on consecutive cycles. Only called while the block
  // is idle, so the predictor can take the new values at once.
  task automatic set_config(input int pages, input int bytes);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_PAGES_IN_USE;
    cfg_data  <= pages[REG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_PAGE_SIZE;
    cfg_data  <= bytes[REG_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    pages_reg = pages & 'h1FF;
    bytes_reg = bytes & 'h1FFFF;
  endtask

  // The reset values of both registers, with no write before the requests.
  task automatic test_reset_defaults();
    send_request(MODE_ALLOC, 16'h0000, 9'd1, 8'd0);
    send_request(MODE_LOCATE, 16'h0000, 9'd0, 8'd0);
    wait_idle();
  endtask

  // Counts of zero, beyond the table and exactly the table, and a page size
  // large enough for the byte address to wrap.
  task automatic test_allocate_limits();
    set_config(256, 131071);
    send_request(MODE_ALLOC, 16'h1234, 9'd0, 8'd0);
    send_request(MODE_ALLOC, 16'h1234, 9'h1FF, 8'd0);
    send_request(MODE_ALLOC, 16'h1234, 9'd257, 8'd0);
    send_request(MODE_ALLOC, 16'hFFFF, 9'd256, 8'd0);
    send_request(MODE_FREE, 16'h0000, 9'd0, 8'd0);
    send_request(MODE_ALLOC, 16'hFFFF, 9'd256, 8'hFF);
    send_request(MODE_LOCATE, 16'hFFFF, 9'h1FF, 8'hFF);
    send_request(MODE_LOCATE, 16'hFFFF, 9'd0, 8'd0);
    send_request(MODE_FREE, 16'hFFFF, 9'd0, 8'd0);
    send_request(MODE_FREE, 16'hFFFF, 9'd0, 8'd0);
    wait_idle();
  endtask

  // The spare mode value, with every other field at its top.
  task automatic test_unused_mode();
    send_request(MODE_UNUSED, 16'hFFFF, 9'h1FF, 8'hFF);
    wait_idle();
  endtask

  // Pages above a shrunk limit keep their owner but cannot be seen or freed
  // until the limit grows again; an oversized limit saturates at the table.
  task automatic test_shrink_and_grow();
    set_config(256, 3);
    send_request(MODE_ALLOC, 16'h00A5, 9'd4, 8'd0);
    send_request(MODE_ALLOC, 16'h5A00, 9'd4, 8'd0);
    wait_idle();
    set_config(4, 3);
    send_request(MODE_LOCATE, 16'h5A00, 9'd0, 8'd0);
    send_request(MODE_FREE, 16'h5A00, 9'd0, 8'd0);
    send_request(MODE_ALLOC, 16'h0F0F, 9'd1, 8'd0);
    wait_idle();
    set_config(300, 65536);
    send_request(MODE_LOCATE, 16'h5A00, 9'd0, 8'd3);
    send_request(MODE_FREE, 16'h00A5, 9'd0, 8'd0);
    send_request(MODE_FREE, 16'h5A00, 9'd0, 8'd0);
    wait_idle();
  endtask

  // With no managed pages every mode must fail.
  task automatic test_no_managed_pages();
    set_config(0, 1);
    send_request(MODE_ALLOC, 16'h0007, 9'd1, 8'd0);
    send_request(MODE_FREE, 16'h0007, 9'd0, 8'd0);
    send_request(MODE_LOCATE, 16'h0007, 9'd0, 8'd0);
    wait_idle();
  endtask

  // Mostly coherent traffic from a small set of processes, so that frees and
  // locates find pages that were really allocated, with some fully random
  // requests mixed in. Each phase runs under different register settings and
  // the table carries over from one phase to the next.
  task automatic test_random_traffic();
    int phase_pages [RANDOM_PHASES] = '{16, 64, 256, 8, 40, 511, 128};
    int phase_bytes [RANDOM_PHASES] = '{4096, 1, 65536, 0, 131071, 300, 256};
    logic [PIDF_W-1:0] pool [8];
    logic [PIDF_W-1:0] pid;
    logic [COUNT_W-1:0] count;
    logic [INDEX_W-1:0] index;
    int span, quarter, roll, pick, n;
    pool[0] = 16'h0000;
    pool[1] = 16'hFFFF;
    for (n = 2; n < 8; n++) pool[n] = PIDF_W'($urandom_range(0, 65535));
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_config(phase_pages[ph], phase_bytes[ph]);
      span = (pages_reg < NUM_PAGES) ? pages_reg : NUM_PAGES;
      if (span == 0) span = 1;
      quarter = (span / 4 > 0) ? span / 4 : 1;
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        roll = $urandom_range(0, 99);
        pid = ($urandom_range(0, 9) == 0) ? PIDF_W'($urandom_range(0, 65535))
                                          : pool[$urandom_range(0, 7)];
        if (roll < 45) begin
          pick = $urandom_range(0, 99);
          if (pick < 85) count = COUNT_W'($urandom_range(1, quarter));
          else if (pick < 97) count = COUNT_W'($urandom_range(1, span));
          else count = COUNT_W'($urandom_range(0, 511));
          send_request(MODE_ALLOC, pid, count, INDEX_W'($urandom_range(0, 255)));
        end else if (roll < 65) begin
          send_request(MODE_FREE, pid, COUNT_W'($urandom_range(0, 511)),
                       INDEX_W'($urandom_range(0, 255)));
        end else if (roll < 95) begin
          index = ($urandom_range(0, 4) == 0) ? INDEX_W'($urandom_range(0, 255))
                                              : INDEX_W'($urandom_range(0, 7));
          send_request(MODE_LOCATE, pid, COUNT_W'($urandom_range(0, 511)), index);
        end else begin
          // Noise: any mode, the spare one included, with arbitrary fields.
          send_request(MODE_W'($urandom_range(0, 3)), PIDF_W'($urandom_range(0, 65535)),
                       COUNT_W'($urandom_range(0, 511)), INDEX_W'($urandom_range(0, 255)));
        end
      end
      wait_idle();
    end
  endtask

  // The receiver has its own stall pattern: short bursts of ready and stall,
  // sometimes a long stall, and now and then a long open stretch.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 15) begin
        rx_ready = 1'b1;
        rx_left  = $urandom_range(50, 200);
      end else if (rx_roll < 22) begin
        rx_ready = 1'b0;
        rx_left  = $urandom_range(10, 40);
      end else if (rx_roll < 55) begin
        rx_ready = 1'b0;
        rx_left  = $urandom_range(1, 6);
      end else begin
        rx_ready = 1'b1;
        rx_left  = $urandom_range(1, 10);
      end
    end
    rx_left--;
    m_axis_tready <= rx_ready;
  end

  // Every result taken from the block is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaited_outcomes.size() == 0) begin
        $error("result with no request outstanding: tdata %h", m_axis_tdata);
        error_count++;
      end else begin
        want = awaited_outcomes.pop_front();
        if (m_axis_tdata[1:0] !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
          error_count++;
        end
        if (m_axis_tdata[9:2] !== want.page) begin
          $error("page_number mismatch: expected %0d, got %0d", want.page, m_axis_tdata[9:2]);
          error_count++;
        end
        if (m_axis_tdata[33:10] !== want.addr) begin
          $error("byte_address mismatch: expected %0d, got %0d",
                 want.addr, m_axis_tdata[33:10]);
          error_count++;
        end
      end
    end
  end

  // Guard against a hang: a run that never drains ends here as a failure.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    // Reset is released on a falling edge. The block then clears its table
    // before it takes the first request.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_allocate_limits();
    test_unused_mode();
    test_shrink_and_grow();
    test_no_managed_pages();
    test_random_traffic();
    wait_idle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[contiguous_page_allocator.f]
sv/cpa_pkg.sv
sv/cpa_ram.sv
sv/cpa_seq.sv
sv/contiguous_page_allocator.sv
dv/tb_contiguous_page_allocator.sv
